// ===== rtl/pbct_pkg.sv =====
// ----------------------------------------------------------------------------
// pbct_pkg
// Shared codes, field widths and controller/datapath interface types for the
// piece and block completion tracker.
// ----------------------------------------------------------------------------
package pbct_pkg;

    localparam int MODE_W     = 4;
    localparam int IDX_W      = 12;
    localparam int TOTAL_W    = 13;
    localparam int BPP_W      = 7;
    localparam int REQ_W      = 8;
    localparam int COUNT_W    = 7;
    localparam int ERR_W      = 2;
    localparam int CFG_W      = 13;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;
    localparam logic [BPP_W-1:0]   BPP_RESET   = 7'd16;
    localparam logic [REQ_W-1:0]   REQ_LIMIT   = 8'd255;

    // Configuration register indexes
    localparam logic REG_TOTAL_BLOCKS = 1'b0;
    localparam logic REG_BPP          = 1'b1;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_BLOCK_ADD   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_REQ_ADD     = 4'd1;
    localparam logic [MODE_W-1:0] MODE_REQ_DROP    = 4'd2;
    localparam logic [MODE_W-1:0] MODE_PIECE_ADD   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_PIECE_DEL   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_PIECE_QUERY = 4'd5;
    localparam logic [MODE_W-1:0] MODE_FIRST_MISS  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_LEAST_REQ   = 4'd7;
    localparam logic [MODE_W-1:0] MODE_CLEAR       = 4'd8;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
    localparam logic [ERR_W-1:0] ERR_REQ   = 2'd2;

    typedef struct packed {
        logic capture;
        logic sweep_init;
        logic sweep_step;
        logic clear_res;
        logic err_range;
        logic div_init;
        logic div_step;
        logic mul_sel_q;
        logic mul_load;
        logic bupd;
        logic pchk;
        logic walk;
        logic pwr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              blk_ok;
        logic              piece_ok;
        logic              sweep_last;
        logic              div_last;
        logic              walk_done;
        logic              out_free;
    } status_t;

endpackage

// ===== rtl/pbct_ram.sv =====
// ----------------------------------------------------------------------------
// pbct_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/pbct_datapath.sv =====
// ----------------------------------------------------------------------------
// pbct_datapath
// Configuration, block and piece stores, divider, walk unit and result
// registers of the completion tracker.
// ----------------------------------------------------------------------------
module pbct_datapath #(
    parameter int MAX_BLOCKS           = 4096,
    parameter int MAX_PIECES           = 256,
    parameter int MAX_BLOCKS_PER_PIECE = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [pbct_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [pbct_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [pbct_pkg::MODE_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pbct_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  pbct_pkg::cmd_t                     cmd,
    output pbct_pkg::status_t                  status
);

    localparam int BW    = $clog2(MAX_BLOCKS);
    localparam int PW    = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int BPW   = $clog2(MAX_BLOCKS_PER_PIECE + 1);
    localparam int XW    = $clog2(4096 * MAX_BLOCKS_PER_PIECE
                                  + MAX_PIECES * MAX_BLOCKS_PER_PIECE + MAX_BLOCKS + 8192);
    localparam int SWEEP = (MAX_BLOCKS > MAX_PIECES) ? MAX_BLOCKS : MAX_PIECES;
    localparam int CLW   = $clog2(SWEEP);
    localparam int MULW  = pbct_pkg::IDX_W + BPW;
    localparam int PWD   = 1 + 2 * BPW;
    localparam int BWD   = 1 + pbct_pkg::REQ_W;
    localparam int DIVC_W = $clog2(pbct_pkg::IDX_W);
    localparam int REQ_W_P1 = pbct_pkg::REQ_W + 1;

    // Configuration
    logic [pbct_pkg::TOTAL_W-1:0] total_reg;
    logic [pbct_pkg::BPP_W-1:0]   bpp_reg;

    // Captured item
    logic [pbct_pkg::MODE_W-1:0]  mode_reg;
    logic [pbct_pkg::IDX_W-1:0]   idx_reg;

    // Divider
    logic [pbct_pkg::IDX_W-1:0]   q_reg, q_next;
    logic [BPW:0]                 rem_reg, rem_next;
    logic [DIVC_W-1:0]            div_cnt_reg;

    // Geometry and walk
    logic [XW-1:0]                start_reg;
    logic [BPW-1:0]               size_reg;
    logic [BPW-1:0]               issue_cnt_reg;
    logic                         rd_valid_reg;
    logic [BW-1:0]                rd_addr_reg;

    // Clearing sweep
    logic [CLW-1:0]               sweep_cnt_reg;
    logic [XW-1:0]                pstart_reg;

    // Result
    logic                         found_reg, found_next;
    logic [BW-1:0]                blk_reg, blk_next;
    logic [REQ_W_P1-1:0]          best_reg, best_next;
    logic                         ph_reg, ph_next;
    logic [BPW-1:0]               pc_reg, pc_next;
    logic [BPW-1:0]               pm_reg, pm_next;
    logic                         report_reg, report_next;
    logic [pbct_pkg::ERR_W-1:0]   err_reg, err_next;
    logic                         out_valid_reg;
    logic [pbct_pkg::OUT_DATA_W-1:0] out_data_reg;

    // Memory ports
    logic           bwe;
    logic [BW-1:0]  bwaddr, braddr;
    logic [BWD-1:0] bwdata, brdata;
    logic           pwe;
    logic [PW-1:0]  pwaddr, praddr;
    logic [PWD-1:0] pwdata, prdata;

    logic [BPW-1:0] eff_b;
    logic [XW-1:0]  b_x, n_x, lim_x, idx_x, q_x, issue_x, cnt_x;
    logic [MULW-1:0] prod;
    logic [BPW-1:0] cur_size, sweep_size;
    logic           issued;
    logic           bh, ph_in;
    logic [pbct_pkg::REQ_W-1:0] br;
    logic [BPW-1:0] pc_in, pm_in;
    logic [BPW:0]   rem_sh;

    function automatic logic [BPW-1:0] piece_len(input logic [XW-1:0] st,
                                                 input logic [XW-1:0] n,
                                                 input logic [XW-1:0] b);
        logic [XW-1:0] rest;
        begin
            rest = (st < n) ? (n - st) : '0;
            piece_len = (rest < b) ? rest[BPW-1:0] : b[BPW-1:0];
        end
    endfunction

    // Effective geometry: piece size clamped, block count limited.
    always_comb
    begin
        if (bpp_reg == '0)
        begin
            eff_b = BPW'(1);
        end
        else if ({2'b00, bpp_reg} > 9'(MAX_BLOCKS_PER_PIECE))
        begin
            eff_b = BPW'(MAX_BLOCKS_PER_PIECE);
        end
        else
        begin
            eff_b = BPW'(bpp_reg);
        end
        b_x   = XW'(eff_b);
        lim_x = XW'(MAX_PIECES) * b_x;
        n_x   = XW'(total_reg);
        if (n_x > XW'(MAX_BLOCKS))
        begin
            n_x = XW'(MAX_BLOCKS);
        end
        if (n_x > lim_x)
        begin
            n_x = lim_x;
        end
    end

    assign idx_x      = XW'(idx_reg);
    assign q_x        = XW'(q_reg);
    assign cnt_x      = XW'(sweep_cnt_reg);
    assign issue_x    = start_reg + XW'(issue_cnt_reg);
    assign prod       = MULW'(cmd.mul_sel_q ? q_reg : idx_reg) * MULW'(eff_b);
    assign cur_size   = piece_len(start_reg, n_x, b_x);
    assign sweep_size = piece_len(pstart_reg, n_x, b_x);
    assign issued     = cmd.walk && (issue_cnt_reg != size_reg);

    assign bh    = brdata[pbct_pkg::REQ_W];
    assign br    = brdata[pbct_pkg::REQ_W-1:0];
    assign ph_in = prdata[2*BPW];
    assign pc_in = prdata[2*BPW-1:BPW];
    assign pm_in = prdata[BPW-1:0];

    assign braddr = cmd.walk ? issue_x[BW-1:0] : idx_x[BW-1:0];
    assign praddr = (mode_reg <= pbct_pkg::MODE_REQ_DROP) ? q_x[PW-1:0] : idx_x[PW-1:0];

    pbct_ram #(.WIDTH(BWD), .DEPTH(MAX_BLOCKS)) u_block_ram (
        .clk   (clk),
        .we    (bwe),
        .waddr (bwaddr),
        .wdata (bwdata),
        .raddr (braddr),
        .rdata (brdata)
    );

    pbct_ram #(.WIDTH(PWD), .DEPTH(MAX_PIECES)) u_piece_ram (
        .clk   (clk),
        .we    (pwe),
        .waddr (pwaddr),
        .wdata (pwdata),
        .raddr (praddr),
        .rdata (prdata)
    );

    // Restoring divider step: one quotient bit per cycle.
    always_comb
    begin
        rem_sh = {rem_reg[BPW-1:0], q_reg[pbct_pkg::IDX_W-1]};
        if (rem_sh >= (BPW+1)'(eff_b))
        begin
            rem_next = rem_sh - (BPW+1)'(eff_b);
            q_next   = {q_reg[pbct_pkg::IDX_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh;
            q_next   = {q_reg[pbct_pkg::IDX_W-2:0], 1'b0};
        end
    end

    // Store updates and result bookkeeping.
    always_comb
    begin
        logic [pbct_pkg::REQ_W-1:0] nbr;
        logic                       nbh;
        nbr         = br;
        nbh         = bh;
        found_next  = found_reg;
        blk_next    = blk_reg;
        best_next   = best_reg;
        ph_next     = ph_reg;
        pc_next     = pc_reg;
        pm_next     = pm_reg;
        report_next = report_reg;
        err_next    = err_reg;
        bwe    = 1'b0;
        bwaddr = idx_x[BW-1:0];
        bwdata = '0;
        pwe    = 1'b0;
        pwaddr = idx_x[PW-1:0];
        pwdata = '0;

        if (cmd.clear_res)
        begin
            found_next  = 1'b0;
            blk_next    = '0;
            best_next   = {1'b1, {pbct_pkg::REQ_W{1'b0}}};
            report_next = 1'b0;
            err_next    = cmd.err_range ? pbct_pkg::ERR_RANGE : pbct_pkg::ERR_OK;
        end

        if (cmd.sweep_step)
        begin
            if (cnt_x < XW'(MAX_BLOCKS))
            begin
                bwe    = 1'b1;
                bwaddr = sweep_cnt_reg[BW-1:0];
            end
            if (cnt_x < XW'(MAX_PIECES))
            begin
                pwe    = 1'b1;
                pwaddr = sweep_cnt_reg[PW-1:0];
                pwdata = {1'b0, {BPW{1'b0}}, sweep_size};
            end
        end

        if (cmd.bupd)
        begin
            ph_next     = ph_in;
            pc_next     = pc_in;
            pm_next     = pm_in;
            report_next = 1'b1;
            case (mode_reg)
                pbct_pkg::MODE_BLOCK_ADD:
                begin
                    if (!bh)
                    begin
                        pc_next = pc_in + BPW'(1);
                        if (pc_next == cur_size)
                        begin
                            ph_next = 1'b1;
                        end
                        if (br == '0 && pm_in != '0)
                        begin
                            pm_next = pm_in - BPW'(1);
                        end
                        nbh = 1'b1;
                    end
                end
                pbct_pkg::MODE_REQ_ADD:
                begin
                    if (br >= pbct_pkg::REQ_LIMIT)
                    begin
                        err_next = pbct_pkg::ERR_REQ;
                    end
                    else
                    begin
                        if (br == '0 && !bh && pm_in != '0)
                        begin
                            pm_next = pm_in - BPW'(1);
                        end
                        nbr = br + 8'd1;
                    end
                end
                default:
                begin
                    if (br == '0)
                    begin
                        err_next = pbct_pkg::ERR_REQ;
                    end
                    else
                    begin
                        nbr = br - 8'd1;
                        if (nbr == '0 && !bh)
                        begin
                            pm_next = pm_in + BPW'(1);
                        end
                    end
                end
            endcase
            bwe    = 1'b1;
            bwaddr = idx_x[BW-1:0];
            bwdata = {nbh, nbr};
            pwe    = 1'b1;
            pwaddr = q_x[PW-1:0];
            pwdata = {ph_next, pc_next, pm_next};
        end

        if (cmd.pchk)
        begin
            if (status.piece_ok)
            begin
                report_next = 1'b1;
                ph_next     = ph_in;
                pc_next     = pc_in;
                pm_next     = pm_in;
            end
            else
            begin
                err_next = pbct_pkg::ERR_RANGE;
            end
        end

        // One block of the piece per cycle, handled in the cycle after its read.
        if (rd_valid_reg)
        begin
            case (mode_reg)
                pbct_pkg::MODE_PIECE_ADD:
                begin
                    bwe    = 1'b1;
                    bwaddr = rd_addr_reg;
                    bwdata = {1'b1, br};
                    if (!bh && br == '0 && pm_reg != '0)
                    begin
                        pm_next = pm_reg - BPW'(1);
                    end
                end
                pbct_pkg::MODE_PIECE_DEL:
                begin
                    bwe    = 1'b1;
                    bwaddr = rd_addr_reg;
                    bwdata = {1'b0, br};
                    if (bh && br == '0)
                    begin
                        pm_next = pm_reg + BPW'(1);
                    end
                end
                pbct_pkg::MODE_FIRST_MISS:
                begin
                    if (!found_reg && !bh && br == '0)
                    begin
                        found_next = 1'b1;
                        blk_next   = rd_addr_reg;
                    end
                end
                pbct_pkg::MODE_LEAST_REQ:
                begin
                    if (!bh && {1'b0, br} < best_reg)
                    begin
                        found_next = 1'b1;
                        blk_next   = rd_addr_reg;
                        best_next  = {1'b0, br};
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.pwr)
        begin
            if (mode_reg == pbct_pkg::MODE_PIECE_ADD)
            begin
                ph_next = 1'b1;
                pc_next = size_reg;
            end
            else if (mode_reg == pbct_pkg::MODE_PIECE_DEL)
            begin
                ph_next = 1'b0;
                pc_next = '0;
            end
            if (mode_reg == pbct_pkg::MODE_PIECE_ADD || mode_reg == pbct_pkg::MODE_PIECE_DEL)
            begin
                pwe    = 1'b1;
                pwaddr = idx_x[PW-1:0];
                pwdata = {ph_next, pc_next, pm_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= pbct_pkg::TOTAL_RESET;
            bpp_reg       <= pbct_pkg::BPP_RESET;
            sweep_cnt_reg <= '0;
            pstart_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == pbct_pkg::REG_TOTAL_BLOCKS)
                begin
                    total_reg <= cfg_wdata;
                end
                else
                begin
                    bpp_reg <= cfg_wdata[pbct_pkg::BPP_W-1:0];
                end
            end
            if (cmd.sweep_init)
            begin
                sweep_cnt_reg <= '0;
                pstart_reg    <= '0;
            end
            else if (cmd.sweep_step)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + CLW'(1);
                if (pstart_reg < n_x)
                begin
                    pstart_reg <= pstart_reg + b_x;
                end
            end
            if (cmd.pchk)
            begin
                rd_valid_reg <= 1'b0;
            end
            else
            begin
                rd_valid_reg <= issued;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= s_tuser;
            idx_reg  <= s_tdata[pbct_pkg::IDX_W-1:0];
        end
        if (cmd.div_init)
        begin
            q_reg       <= idx_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg       <= q_next;
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg + DIVC_W'(1);
        end
        if (cmd.mul_load)
        begin
            start_reg <= XW'(prod);
        end
        if (cmd.pchk)
        begin
            size_reg      <= cur_size;
            issue_cnt_reg <= '0;
        end
        else if (issued)
        begin
            issue_cnt_reg <= issue_cnt_reg + BPW'(1);
        end
        rd_addr_reg <= issue_x[BW-1:0];
        found_reg   <= found_next;
        blk_reg     <= blk_next;
        best_reg    <= best_next;
        ph_reg      <= ph_next;
        pc_reg      <= pc_next;
        pm_reg      <= pm_next;
        report_reg  <= report_next;
        err_reg     <= err_next;
        if (cmd.out_load)
        begin
            out_data_reg <= {2'b00,
                             err_reg,
                             report_reg ? pbct_pkg::COUNT_W'(pm_reg) : '0,
                             report_reg ? pbct_pkg::COUNT_W'(pc_reg) : '0,
                             report_reg & ph_reg,
                             found_reg ? best_reg[pbct_pkg::REQ_W-1:0] : '0,
                             found_reg ? pbct_pkg::IDX_W'(XW'(blk_reg)) : '0,
                             found_reg};
        end
    end

    always_comb
    begin
        status            = '0;
        status.mode       = mode_reg;
        status.blk_ok     = idx_x < n_x;
        status.piece_ok   = (idx_x < XW'(MAX_PIECES)) && (start_reg < n_x);
        status.sweep_last = sweep_cnt_reg == CLW'(SWEEP - 1);
        status.div_last   = div_cnt_reg == DIVC_W'(pbct_pkg::IDX_W - 1);
        status.walk_done  = (issue_cnt_reg == size_reg) && !rd_valid_reg;
        status.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/pbct_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbct_ctrl
// Sequencer of the completion tracker: steps one word at a time through
// range check, division, store update, piece walk, clearing sweep and result hand-off.
// ----------------------------------------------------------------------------
module pbct_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pbct_pkg::status_t status,
    output pbct_pkg::cmd_t    cmd
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_WIPE  = 12'b000000000010,
        S_CLEAR = 12'b000000000100,
        S_DISP  = 12'b000000001000,
        S_DIV   = 12'b000000010000,
        S_BMUL  = 12'b000000100000,
        S_BUPD  = 12'b000001000000,
        S_PCHK  = 12'b000010000000,
        S_WALK  = 12'b000100000000,
        S_PWR   = 12'b001000000000,
        S_DONE  = 12'b010000000000,
        S_SPARE = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    // A register write takes priority over a word in the idle state.
    assign s_tready = (state_reg == S_IDLE) && !cfg_we;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    cmd.sweep_init = 1'b1;
                    state_next     = S_WIPE;
                end
                else if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            // A sweep with no result owed (after reset or a register write).
            S_WIPE:
            begin
                if (cfg_we)
                begin
                    cmd.sweep_init = 1'b1;
                end
                else
                begin
                    cmd.sweep_step = 1'b1;
                    if (status.sweep_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_CLEAR:
            begin
                if (cfg_we)
                begin
                    cmd.sweep_init = 1'b1;
                end
                else
                begin
                    cmd.sweep_step = 1'b1;
                    if (status.sweep_last)
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DISP:
            begin
                cmd.clear_res = 1'b1;
                unique case (status.mode) inside
                    [pbct_pkg::MODE_BLOCK_ADD:pbct_pkg::MODE_REQ_DROP]:
                    begin
                        if (status.blk_ok)
                        begin
                            cmd.div_init = 1'b1;
                            state_next   = S_DIV;
                        end
                        else
                        begin
                            cmd.err_range = 1'b1;
                            state_next    = S_DONE;
                        end
                    end
                    [pbct_pkg::MODE_PIECE_ADD:pbct_pkg::MODE_LEAST_REQ]:
                    begin
                        cmd.mul_load = 1'b1;
                        state_next   = S_PCHK;
                    end
                    pbct_pkg::MODE_CLEAR:
                    begin
                        cmd.sweep_init = 1'b1;
                        state_next     = S_CLEAR;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_BMUL;
                end
            end
            S_BMUL:
            begin
                cmd.mul_sel_q = 1'b1;
                cmd.mul_load  = 1'b1;
                state_next    = S_BUPD;
            end
            S_BUPD:
            begin
                cmd.bupd   = 1'b1;
                state_next = S_DONE;
            end
            S_PCHK:
            begin
                cmd.pchk = 1'b1;
                if (!status.piece_ok || status.mode == pbct_pkg::MODE_PIECE_QUERY)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_done)
                begin
                    state_next = S_PWR;
                end
            end
            S_PWR:
            begin
                cmd.pwr    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_WIPE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/piece_block_completion_tracker_top.sv =====
// ----------------------------------------------------------------------------
// piece_block_completion_tracker_top
// Scoreboard of held and requested blocks grouped into pieces.
// ----------------------------------------------------------------------------
// One word is handled at a time. A block operation finds the block's piece
// with a serial divider before it updates the stores. A piece operation
// other than a query walks the piece, reading one block store entry per
// cycle. Clear, reset and a register write while idle or sweeping start a
// sweep of max(MAX_BLOCKS, MAX_PIECES) entries, one entry per cycle (a
// register write restarts it), during which no word is accepted. The result
// sits in an output register, so the next word is taken while it waits.
module piece_block_completion_tracker_top #(
    parameter int MAX_BLOCKS           = 4096,
    parameter int MAX_PIECES           = 256,
    parameter int MAX_BLOCKS_PER_PIECE = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [pbct_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pbct_pkg::IN_DATA_W-1:0]  s_tdata,  // index[11:0], zero pad
    input  logic [pbct_pkg::MODE_W-1:0]     s_tuser,  // mode[3:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // found[0], block_index[12:1], requesters[20:13], piece_complete[21],
    // complete_count[28:22], missing_count[35:29], error[37:36], zero pad
    output logic [pbct_pkg::OUT_DATA_W-1:0] m_tdata
);

    pbct_pkg::cmd_t    cmd;
    pbct_pkg::status_t status;

    pbct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pbct_datapath #(
        .MAX_BLOCKS           (MAX_BLOCKS),
        .MAX_PIECES           (MAX_PIECES),
        .MAX_BLOCKS_PER_PIECE (MAX_BLOCKS_PER_PIECE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
